[hw/rtl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Result kinds, character codes, the result word layout and the
// character-to-sextet map.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;
    localparam int CAP_W   = 16;

    // Reset value of the output capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    // Result queue depth; a burst of three plus two draining words keeps
    // one character per cycle flowing while the result side is ready
    localparam int QUEUE_DEPTH = 5;

    // Most results caused by one character
    localparam int MAX_RESULTS = 3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D; // '='
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41; // 'A'
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A; // 'Z'
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61; // 'a'
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A; // 'z'
    localparam logic [CHAR_W-1:0] CH_DIG_0 = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CH_DIG_9 = 8'h39; // '9'

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One result word
    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [COUNT_W-1:0] byte_count;
        logic               run_last;
    } result_t;

    // Burst of results from the decoder into the queue
    typedef struct packed {
        logic [1:0]    n;      // number of valid items, 0..3
        result_t [2:0] item;   // item[0] goes out first
    } push_t;

    // Bit 6 set: not in the alphabet; bits 5:0: sextet value
    function automatic logic [6:0] sextet_of(input logic [CHAR_W-1:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            r = {1'b0, 6'(c - CH_UP_A)};
        end
        else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            r = {1'b0, 6'(c - CH_LO_A + 8'd26)};
        end
        else if (c inside {[CH_DIG_0:CH_DIG_9]}) begin
            r = {1'b0, 6'(c - CH_DIG_0 + 8'd52)};
        end
        else if (c == CH_PLUS) begin
            r = 7'd62;
        end
        else if (c == CH_SLASH) begin
            r = 7'd63;
        end
        return r;
    endfunction

endpackage

[hw/rtl/b64d_if.sv]
// ----------------------------------------------------------------------------
// b64d_if: stream channels of the base64 stream decoder
// Character channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface b64d_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] byte_count;
    logic        run_last;

    modport source (output valid, output kind, output byte_value,
                    output byte_count, output run_last, input ready);
    modport sink   (input valid, input kind, input byte_value,
                    input byte_count, input run_last, output ready);
endinterface

[hw/rtl/b64d_decode.sv]
// ----------------------------------------------------------------------------
// b64d_decode: per-string decode state and one-character step
// Maps the registered character to a sextet, updates the group and
// byte count, and builds the burst of results it causes.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [b64d_pkg::CHAR_W-1:0]  char_code,
    input  logic [b64d_pkg::CAP_W-1:0]   out_capacity,
    output b64d_pkg::push_t              push
);
    import b64d_pkg::*;

    logic [17:0]        hold_reg,    hold_next;
    logic [1:0]         cnt_reg,     cnt_next;
    logic [COUNT_W-1:0] bytes_reg,   bytes_next;
    logic               stopped_reg, stopped_next;
    logic               failed_reg,  failed_next;

    logic [6:0]         sext;
    logic [CAP_W-1:0]   limit;
    logic [COUNT_W-1:0] room;
    logic               full;
    logic [1:0]         want;
    logic [1:0]         k;
    logic [BYTE_W-1:0]  dbyte [3];
    logic               term;
    logic               err;
    logic [23:0]        group;
    logic [COUNT_W-1:0] total;
    logic [1:0]         n;

    assign sext  = sextet_of(char_code);
    assign limit = (out_capacity == '0) ? '0 : out_capacity - 1'b1;
    assign full  = (bytes_reg >= limit);
    assign room  = full ? '0 : limit - bytes_reg;
    assign group = {hold_reg, sext[5:0]};

    // Step of the string state
    always_comb
    begin
        hold_next    = hold_reg;
        cnt_next     = cnt_reg;
        bytes_next   = bytes_reg;
        stopped_next = stopped_reg;
        failed_next  = failed_reg;
        want         = 2'd0;
        dbyte[0]     = '0;
        dbyte[1]     = '0;
        dbyte[2]     = '0;
        term         = 1'b0;
        err          = 1'b0;
        if (fire) begin
            if (char_code == CH_NUL) begin
                // terminator: flush a partial group, then end result
                if (!failed_reg) begin
                    term = 1'b1;
                    if (cnt_reg == 2'd3) begin
                        want     = 2'd2;
                        dbyte[0] = {hold_reg[17:12], hold_reg[11:10]};
                        dbyte[1] = {hold_reg[9:6], hold_reg[5:2]};
                    end
                    else if (cnt_reg == 2'd2) begin
                        want     = 2'd1;
                        dbyte[0] = {hold_reg[11:6], hold_reg[5:4]};
                    end
                end
                hold_next    = '0;
                cnt_next     = '0;
                bytes_next   = '0;
                stopped_next = 1'b0;
                failed_next  = 1'b0;
            end
            else if (failed_reg || stopped_reg || full) begin
                // ignored until terminator
            end
            else if (char_code inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                // whitespace skipped
            end
            else if (char_code == CH_PAD) begin
                stopped_next = 1'b1;
            end
            else if (sext[6]) begin
                failed_next = 1'b1;
                err         = 1'b1;
            end
            else if (cnt_reg != 2'd3) begin
                hold_next = {hold_reg[11:0], sext[5:0]};
                cnt_next  = cnt_reg + 2'd1;
            end
            else begin
                // fourth sextet completes a group of three bytes
                want      = 2'd3;
                dbyte[0]  = group[23:16];
                dbyte[1]  = group[15:8];
                dbyte[2]  = group[7:0];
                hold_next = '0;
                cnt_next  = '0;
            end
        end
        // bytes that still fit under the limit
        k     = (room >= {14'd0, want}) ? want : room[1:0];
        total = bytes_reg + {14'd0, k};
        if (!term && fire && char_code != CH_NUL) begin
            bytes_next = total;
        end
    end

    // Result burst
    assign n = k + {1'b0, term} + {1'b0, err};

    always_comb
    begin
        push.n = n;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            push.item[i] = '0;
            if (2'(i) < k) begin
                push.item[i].kind       = KIND_DATA;
                push.item[i].byte_value = dbyte[i];
            end
            else if (term && 2'(i) == k) begin
                push.item[i].kind       = KIND_END;
                push.item[i].byte_count = total;
            end
            push.item[i].run_last = (2'(i) + 2'd1 == n);
        end
        if (err) begin
            push.item[0].kind = KIND_ERROR;
        end
    end

    // String state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_reg    <= '0;
            cnt_reg     <= '0;
            bytes_reg   <= '0;
            stopped_reg <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else begin
            hold_reg    <= hold_next;
            cnt_reg     <= cnt_next;
            bytes_reg   <= bytes_next;
            stopped_reg <= stopped_next;
            failed_reg  <= failed_next;
        end
    end

    // Checks
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && err) |-> (push.n == 2'd1))
        else $error("error result not alone in its burst");
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && char_code == CH_NUL) |=>
        (cnt_reg == 2'd0 && bytes_reg == '0 && !failed_reg && !stopped_reg))
        else $error("string state not cleared after terminator");
    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (push.n == 2'd0))
        else $error("results pushed without a character");

endmodule

[hw/rtl/b64d_result_queue.sv]
// ----------------------------------------------------------------------------
// b64d_result_queue: shifting result queue
// Takes a burst of up to three results per cycle and hands them out
// one word per cycle from the head register while the result side is ready.
// ----------------------------------------------------------------------------
module b64d_result_queue #(
    parameter int QueueDepth = b64d_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64d_pkg::push_t      push,
    output logic                 room,
    b64d_result_if.source        results
);
    import b64d_pkg::*;

    localparam int CW = $clog2(QueueDepth + 1);
    localparam int SW = CW + 1;

    result_t         slot_reg  [QueueDepth];
    result_t         slot_next [QueueDepth];
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;
    logic [CW-1:0]   base;
    logic [CW-1:0]   offset;

    assign pop  = (count_reg != '0) && results.ready;
    assign base = count_reg - CW'(pop);

    // Room for a full burst after this cycle's pop
    assign room = (SW'(base) + SW'(MAX_RESULTS) <= SW'(QueueDepth));

    // Shift on pop, append the burst behind the survivors
    always_comb
    begin
        for (int j = 0; j < QueueDepth; j++) begin
            offset       = CW'(j) - base;
            slot_next[j] = slot_reg[j];
            if (CW'(j) < base) begin
                if (pop && j + 1 < QueueDepth) begin
                    slot_next[j] = slot_reg[(j + 1) % QueueDepth];
                end
            end
            else if (offset < CW'(push.n)) begin
                slot_next[j] = push.item[offset[1:0]];
            end
        end
        count_next = base + CW'(push.n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QueueDepth; j++) begin
            slot_reg[j] <= slot_next[j];
        end
    end

    // Head of queue drives the channel
    assign results.valid      = (count_reg != '0);
    assign results.kind       = slot_reg[0].kind;
    assign results.byte_value = slot_reg[0].byte_value;
    assign results.byte_count = slot_reg[0].byte_count;
    assign results.run_last   = slot_reg[0].run_last;

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("burst pushed without room");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QueueDepth))
        else $error("queue count beyond depth");
    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |=>
        (results.valid && $stable(slot_reg[0])))
        else $error("head word changed while stalled");

endmodule

[hw/rtl/base64_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top: base64 stream decoder
// Decodes one character word per cycle, while the result queue has room, into data bytes, end and error
// results, with a capacity limit on the decoded bytes of each string.
//
//   channel   dir  words                       handshake
//   chars     in   char_code[7:0]              valid/ready
//   results   out  kind, byte_value,           valid/ready
//                  byte_count, run_last
//   cfg       in   cfg_wr_data[15:0]           cfg_wr_en, no wait
//
// One character is taken every cycle while results keep flowing; the
// output side moves one result word per cycle while ready, so a four-character group
// that yields three bytes gives three words on the result channel.
// Path: input register, then the decode step into the result queue head register.
// Reset clears string state, the queue and sets capacity to 256.
// A stalled result channel fills the five-entry queue, then chars.ready
// drops until room for a full burst of three is back.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
    parameter int QueueDepth = b64d_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    b64d_char_if.sink                  chars,
    b64d_result_if.source              results,
    input  logic                       cfg_wr_en,
    input  logic [b64d_pkg::CAP_W-1:0] cfg_wr_data
);
    import b64d_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              char_valid_reg;
    logic              room;
    logic              fire;
    push_t             push;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Input register; decode fires when the queue has room
    assign fire        = char_valid_reg && room;
    assign chars.ready = !char_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_valid_reg <= 1'b0;
        end
        else if (chars.ready) begin
            char_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid) begin
            char_reg <= chars.char_code;
        end
    end

    b64d_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .char_code    (char_reg),
        .out_capacity (cap_reg),
        .push         (push)
    );

    b64d_result_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .results (results)
    );

endmodule
